[hw/rtl/ppap_pkg.sv]
// shared types and codes of the per-client packet admission policer
package ppap_pkg;

	// request kinds
	localparam logic [2:0] KIND_PACKET    = 3'd0;
	localparam logic [2:0] KIND_TICK      = 3'd1;
	localparam logic [2:0] KIND_CONNECT   = 3'd2;
	localparam logic [2:0] KIND_DISCONN   = 3'd3;
	localparam logic [2:0] KIND_HANDSHAKE = 3'd4;
	localparam logic [2:0] KIND_LOAD      = 3'd5;

	// verdicts
	localparam logic [1:0] VERDICT_ACCEPT_ENGINE = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT_GAME   = 2'd1;
	localparam logic [1:0] VERDICT_DROP_SILENT   = 2'd2;
	localparam logic [1:0] VERDICT_DROP_VIOL     = 2'd3;

	// drop reasons
	localparam logic [2:0] REASON_NONE         = 3'd0;
	localparam logic [2:0] REASON_UNKNOWN_SLOT = 3'd1;
	localparam logic [2:0] REASON_BUDGET       = 3'd2;
	localparam logic [2:0] REASON_NOT_SENDABLE = 3'd3;
	localparam logic [2:0] REASON_SIZE         = 3'd4;
	localparam logic [2:0] REASON_HANDSHAKE    = 3'd5;
	localparam logic [2:0] REASON_TYPE_CAP     = 3'd6;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MAX_PACKETS = 2'd0;
	localparam logic [1:0] REG_MAX_BYTES   = 2'd1;
	localparam logic [1:0] REG_VIOL_LIMIT  = 2'd2;

	localparam logic [15:0] MAX_PACKETS_RESET = 16'd64;
	localparam logic [23:0] MAX_BYTES_RESET   = 24'd65536;
	localparam logic [7:0]  VIOL_LIMIT_RESET  = 8'd32;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  client_slot;
		logic [7:0]  packet_type;
		logic [15:0] packet_size;
		logic [15:0] contract_min_size;
		logic [15:0] contract_max_size;
		logic [7:0]  contract_per_tick;
		logic        contract_needs_handshake;
		logic        contract_overcap_violates;
	} pkt_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [2:0] drop_reason;
		logic [7:0] violation_total;
		logic       disconnect;
		logic [5:0] slot_out;
	} res_t;

	// per-slot tick counters
	typedef struct packed {
		logic [15:0] pkts;
		logic [23:0] bytes;
	} cnt_t;

	// per-slot connection state
	typedef struct packed {
		logic       valid;
		logic       hs;
		logic [7:0] viol;
	} slot_t;

	typedef struct packed {
		logic [15:0] min_size;
		logic [15:0] max_size;
		logic [7:0]  per_tick;
		logic        needs_hs;
		logic        overcap_violates;
	} contract_t;

	typedef enum logic [1:0] {
		SW_RESET = 2'd0,
		SW_TICK  = 2'd1,
		SW_SLOT  = 2'd2
	} sweep_mode_t;

	typedef struct packed {
		logic        capture;
		logic        commit;
		logic        sweep;
		sweep_mode_t mode;
	} ctl_cmd_t;

	typedef struct packed {
		logic item_tick;
		logic item_conn;
		logic out_free;
	} ctl_sts_t;

endpackage

[hw/rtl/ppap_ctrl.sv]
// controller state machine: capture, read, execute and clearing sweeps
module ppap_ctrl import ppap_pkg::*; #(
	parameter int CLIENT_SLOTS = 64,
	parameter int ENGINE_TYPES = 16,
	localparam int TOT  = CLIENT_SLOTS * ENGINE_TYPES,
	localparam int TI_W = (TOT > 1) ? $clog2(TOT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pkt_valid,
	output logic            pkt_stall,
	input  ctl_sts_t        sts,
	output ctl_cmd_t        cmd,
	output logic [TI_W-1:0] sweep_idx
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_SWEEP = 4'b1000
	} state_t;

	state_t          state_q;
	sweep_mode_t     mode_q;
	logic [TI_W-1:0] idx_q;
	logic [TI_W-1:0] last_idx;

	assign last_idx = (mode_q == SW_SLOT) ? TI_W'(ENGINE_TYPES - 1) : TI_W'(TOT - 1);

	// commands
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && pkt_valid;
		cmd.commit  = (state_q == ST_EXEC) && sts.out_free;
		cmd.sweep   = (state_q == ST_SWEEP);
		cmd.mode    = mode_q;
	end

	assign pkt_stall = (state_q != ST_IDLE);
	assign sweep_idx = idx_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			mode_q  <= SW_RESET;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pkt_valid) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (sts.out_free) begin
						idx_q <= '0;
						if (sts.item_tick) begin
							mode_q  <= SW_TICK;
							state_q <= ST_SWEEP;
						end else if (sts.item_conn) begin
							mode_q  <= SW_SLOT;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SWEEP: begin
					if (idx_q == last_idx) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + TI_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ppap_dp.sv]
// datapath: slot, type-count and contract memories, gate logic, result register
module ppap_dp import ppap_pkg::*; #(
	parameter int CLIENT_SLOTS = 64,
	parameter int ENGINE_TYPES = 16,
	localparam int TOT    = CLIENT_SLOTS * ENGINE_TYPES,
	localparam int TI_W   = (TOT > 1) ? $clog2(TOT) : 1,
	localparam int SLOT_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1,
	localparam int CT_W   = (ENGINE_TYPES > 1) ? $clog2(ENGINE_TYPES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pkt_t            pkt,
	input  ctl_cmd_t        cmd,
	input  logic [TI_W-1:0] sweep_idx,
	output ctl_sts_t        sts,
	input  logic [15:0]     max_packets,
	input  logic [23:0]     max_bytes,
	input  logic [7:0]      viol_limit,
	output logic            res_valid,
	input  logic            res_stall,
	output res_t            res
);

	cnt_t      mem_a [CLIENT_SLOTS];
	slot_t     mem_b [CLIENT_SLOTS];
	logic [7:0] mem_t [TOT];
	contract_t mem_c [ENGINE_TYPES];
	logic [ENGINE_TYPES-1:0] ctr_vld_q;

	pkt_t              item_q;
	logic              in_range_q;
	logic              type_ok_q;
	logic [SLOT_W-1:0] slot_idx_q;
	logic [TI_W-1:0]   ti_base_q;
	logic [TI_W-1:0]   ti_q;

	cnt_t       a_rd_q;
	slot_t      b_rd_q;
	logic [7:0] t_rd_q;
	contract_t  c_rd_q;
	logic       c_ok_q;

	res_t res_q;
	logic res_valid_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q     <= pkt;
			in_range_q <= (11'(pkt.client_slot) < 11'(CLIENT_SLOTS));
			type_ok_q  <= (9'(pkt.packet_type) < 9'(ENGINE_TYPES));
			slot_idx_q <= SLOT_W'(pkt.client_slot);
			ti_base_q  <= TI_W'(SLOT_W'(pkt.client_slot) * ENGINE_TYPES);
			ti_q       <= TI_W'(SLOT_W'(pkt.client_slot) * ENGINE_TYPES)
				+ TI_W'(CT_W'(pkt.packet_type));
		end
	end

	// status to controller
	always_comb begin
		sts.item_tick = (item_q.kind == KIND_TICK);
		sts.item_conn = (item_q.kind == KIND_CONNECT) && in_range_q;
		sts.out_free  = !res_valid_q || !res_stall;
	end

	// gate evaluation
	logic [1:0]  verdict;
	logic [2:0]  reason;
	logic [7:0]  total;
	logic        disc;
	logic        viol, silent;
	logic        a_upd, b_upd, t_upd, c_upd;
	cnt_t        a_wd;
	slot_t       b_wd;
	logic [7:0]  t_wd;
	logic [16:0] newp;
	logic [24:0] newb;
	logic [8:0]  nt;
	logic [7:0]  vnew;
	contract_t   ctr;

	always_comb begin
		verdict = VERDICT_ACCEPT_ENGINE;
		reason  = REASON_NONE;
		total   = 8'd0;
		disc    = 1'b0;
		viol    = 1'b0;
		silent  = 1'b0;
		a_upd   = 1'b0;
		b_upd   = 1'b0;
		t_upd   = 1'b0;
		c_upd   = 1'b0;
		a_wd    = a_rd_q;
		b_wd    = b_rd_q;
		newp    = {1'b0, a_rd_q.pkts} + 17'd1;
		newb    = {1'b0, a_rd_q.bytes} + 25'(item_q.packet_size);
		nt      = {1'b0, t_rd_q} + 9'd1;
		t_wd    = nt[8] ? 8'hFF : nt[7:0];
		vnew    = (b_rd_q.viol != 8'hFF) ? b_rd_q.viol + 8'd1 : b_rd_q.viol;
		ctr     = c_ok_q ? c_rd_q : '0;
		case (item_q.kind)
			KIND_PACKET: begin
				if (item_q.packet_size == 16'd0) begin
					verdict = VERDICT_DROP_SILENT;
				end else if (!in_range_q || !b_rd_q.valid) begin
					verdict = VERDICT_DROP_SILENT;
					reason  = REASON_UNKNOWN_SLOT;
				end else begin
					a_upd = 1'b1;
					a_wd.pkts = newp[16] ? 16'hFFFF : newp[15:0];
					if (newp > {1'b0, max_packets}) begin
						reason = REASON_BUDGET;
						if (a_rd_q.pkts <= max_packets) viol = 1'b1;
						else silent = 1'b1;
					end else begin
						a_wd.bytes = newb[24] ? 24'hFFFFFF : newb[23:0];
						if (newb > {1'b0, max_bytes}) begin
							reason = REASON_BUDGET;
							if (a_rd_q.bytes <= max_bytes) viol = 1'b1;
							else silent = 1'b1;
						end else if (type_ok_q) begin
							if (ctr.max_size == 16'd0) begin
								reason = REASON_NOT_SENDABLE;
								viol   = 1'b1;
							end else if (item_q.packet_size < ctr.min_size ||
								item_q.packet_size > ctr.max_size) begin
								reason = REASON_SIZE;
								viol   = 1'b1;
							end else if (ctr.needs_hs && !b_rd_q.hs) begin
								reason = REASON_HANDSHAKE;
								silent = 1'b1;
							end else begin
								t_upd = 1'b1;
								if (nt > {1'b0, ctr.per_tick}) begin
									reason = REASON_TYPE_CAP;
									if (ctr.overcap_violates) viol = 1'b1;
									else silent = 1'b1;
								end
							end
						end else if (!b_rd_q.hs) begin
							reason = REASON_HANDSHAKE;
							silent = 1'b1;
						end else begin
							verdict = VERDICT_ACCEPT_GAME;
						end
					end
					total = b_rd_q.viol;
					if (viol) begin
						verdict   = VERDICT_DROP_VIOL;
						b_upd     = 1'b1;
						b_wd.viol = vnew;
						total     = vnew;
						if (vnew >= viol_limit) begin
							b_wd.valid = 1'b0;
							disc       = 1'b1;
						end
					end else if (silent) begin
						verdict = VERDICT_DROP_SILENT;
					end
				end
			end
			KIND_CONNECT: begin
				if (in_range_q) begin
					a_upd = 1'b1;
					a_wd  = '0;
					b_upd = 1'b1;
					b_wd  = '{valid: 1'b1, hs: 1'b0, viol: 8'd0};
				end
			end
			KIND_DISCONN: begin
				if (in_range_q) begin
					disc       = b_rd_q.valid;
					b_upd      = 1'b1;
					b_wd.valid = 1'b0;
				end
			end
			KIND_HANDSHAKE: begin
				if (in_range_q && b_rd_q.valid) begin
					b_upd   = 1'b1;
					b_wd.hs = 1'b1;
					total   = b_rd_q.viol;
				end
			end
			KIND_LOAD: begin
				c_upd = type_ok_q;
			end
			default: begin
			end
		endcase
	end

	// write ports: sweep clears or commit
	logic              a_we, b_we, t_we;
	logic [SLOT_W-1:0] ab_addr;
	cnt_t              a_wr;
	slot_t             b_wr;
	logic [TI_W-1:0]   t_addr;
	logic [7:0]        t_wr;
	logic              sw_in_slots;

	assign sw_in_slots = ({1'b0, sweep_idx} < (TI_W + 1)'(CLIENT_SLOTS));

	always_comb begin
		if (cmd.sweep) begin
			a_we    = (cmd.mode != SW_SLOT) && sw_in_slots;
			b_we    = (cmd.mode == SW_RESET) && sw_in_slots;
			ab_addr = SLOT_W'(sweep_idx);
			a_wr    = '0;
			b_wr    = '0;
			t_we    = 1'b1;
			t_addr  = (cmd.mode == SW_SLOT) ? ti_base_q + sweep_idx : sweep_idx;
			t_wr    = 8'd0;
		end else begin
			a_we    = cmd.commit && a_upd;
			b_we    = cmd.commit && b_upd;
			ab_addr = slot_idx_q;
			a_wr    = a_wd;
			b_wr    = b_wd;
			t_we    = cmd.commit && t_upd;
			t_addr  = ti_q;
			t_wr    = t_wd;
		end
	end

	// slot counter memory
	always_ff @(posedge clk) begin
		if (a_we) mem_a[ab_addr] <= a_wr;
		a_rd_q <= mem_a[slot_idx_q];
	end

	// slot state memory
	always_ff @(posedge clk) begin
		if (b_we) mem_b[ab_addr] <= b_wr;
		b_rd_q <= mem_b[slot_idx_q];
	end

	// per-type tick count memory
	always_ff @(posedge clk) begin
		if (t_we) mem_t[t_addr] <= t_wr;
		t_rd_q <= mem_t[ti_q];
	end

	// contract memory
	always_ff @(posedge clk) begin
		if (cmd.commit && c_upd) begin
			mem_c[CT_W'(item_q.packet_type)] <= '{
				min_size:         item_q.contract_min_size,
				max_size:         item_q.contract_max_size,
				per_tick:         item_q.contract_per_tick,
				needs_hs:         item_q.contract_needs_handshake,
				overcap_violates: item_q.contract_overcap_violates};
		end
		c_rd_q <= mem_c[CT_W'(item_q.packet_type)];
		c_ok_q <= type_ok_q && ctr_vld_q[CT_W'(item_q.packet_type)];
	end

	// contract entries loaded since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_vld_q <= '0;
		end else if (cmd.commit && c_upd) begin
			ctr_vld_q[CT_W'(item_q.packet_type)] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= '{verdict: verdict, drop_reason: reason, violation_total: total,
				disconnect: disc, slot_out: item_q.client_slot};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[hw/rtl/per_client_packet_admission_policer.sv]
// top level of the per-client packet admission policer
//
//  channel  | signals                        | direction | payload
//  ---------+--------------------------------+-----------+--------------------------
//  request  | pkt_valid, pkt_stall, pkt      | in        | pkt_t (kind, slot, ...)
//  result   | res_valid, res_stall, res      | out       | res_t (verdict, reason..)
//  config   | psel, penable, pwrite, paddr.. | in/out    | three 32-bit registers
//
// a request passes through capture, memory read, gate evaluation and write-back
// tick start adds a sweep clearing the slot counters and all type counts; connect adds a
// sweep clearing the slot's type counts
// after reset a clearing pass over all slot state and counters runs with pkt_stall high
// the result register holds while res_stall is high; a new request may be taken
// meanwhile, and its write-back waits for the result register to free
module per_client_packet_admission_policer import ppap_pkg::*; #(
	parameter int CLIENT_SLOTS = 64,
	parameter int ENGINE_TYPES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_stall,
	input  pkt_t        pkt,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TOT  = CLIENT_SLOTS * ENGINE_TYPES;
	localparam int TI_W = (TOT > 1) ? $clog2(TOT) : 1;

	logic [15:0]     max_packets_q;
	logic [23:0]     max_bytes_q;
	logic [7:0]      viol_limit_q;
	ctl_cmd_t        cmd;
	ctl_sts_t        sts;
	logic [TI_W-1:0] sweep_idx;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packets_q <= MAX_PACKETS_RESET;
			max_bytes_q   <= MAX_BYTES_RESET;
			viol_limit_q  <= VIOL_LIMIT_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MAX_PACKETS: max_packets_q <= pwdata[15:0];
				REG_MAX_BYTES:   max_bytes_q   <= pwdata[23:0];
				REG_VIOL_LIMIT:  viol_limit_q  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_MAX_PACKETS: prdata = {16'd0, max_packets_q};
			REG_MAX_BYTES:   prdata = {8'd0, max_bytes_q};
			REG_VIOL_LIMIT:  prdata = {24'd0, viol_limit_q};
			default:         prdata = 32'd0;
		endcase
	end

	ppap_ctrl #(
		.CLIENT_SLOTS (CLIENT_SLOTS),
		.ENGINE_TYPES (ENGINE_TYPES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.sts       (sts),
		.cmd       (cmd),
		.sweep_idx (sweep_idx)
	);

	ppap_dp #(
		.CLIENT_SLOTS (CLIENT_SLOTS),
		.ENGINE_TYPES (ENGINE_TYPES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt         (pkt),
		.cmd         (cmd),
		.sweep_idx   (sweep_idx),
		.sts         (sts),
		.max_packets (max_packets_q),
		.max_bytes   (max_bytes_q),
		.viol_limit  (viol_limit_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule

[hw/rtl/ppap_checker.sv]
// port-level checks of the policer and their binding
module ppap_checker import ppap_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pkt_valid,
	input logic pkt_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// one request at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_stall |=> pkt_stall)
		else $error("request taken while previous one in flight");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// accepts carry no reason
	a_accept_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.verdict == VERDICT_ACCEPT_ENGINE ||
			res.verdict == VERDICT_ACCEPT_GAME) |-> res.drop_reason == REASON_NONE)
		else $error("accept with drop reason");

	// a violation names a reason and counts
	a_viol_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.verdict == VERDICT_DROP_VIOL |->
			res.drop_reason != REASON_NONE && res.violation_total != 8'd0)
		else $error("violation without reason or count");

endmodule

bind per_client_packet_admission_policer ppap_checker u_ppap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pkt_valid (pkt_valid),
	.pkt_stall (pkt_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
